// ----- hdl/rotr_pkg.sv -----
package rotr_pkg;

  localparam int Q_SHIFT = 14;
  localparam int PROD_W  = 27;
  localparam int SUM_W   = 28;
  localparam int COORD_W = SUM_W - Q_SHIFT;
  localparam int PIX_W   = 24;

  localparam logic [7:0] WHITE     = 8'hFF;
  localparam logic       CMD_LOAD  = 1'b0;
  localparam logic       CMD_FETCH = 1'b1;

  localparam int APB_AW = 5;

  typedef enum logic [2:0] {
    REG_COS    = 3'd0,
    REG_SIN    = 3'd1,
    REG_OFFX   = 3'd2,
    REG_OFFY   = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_HEIGHT = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] cos_q14;
    logic signed [15:0] sin_q14;
    logic signed [9:0]  offset_x;
    logic signed [9:0]  offset_y;
    logic [8:0]         src_width;
    logic [8:0]         src_height;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic             fetch;
    logic             hit;
    logic [PIX_W-1:0] wdata;
  } acc_t;

endpackage

// ----- hdl/rotr_if.sv -----
interface rotr_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [8:0] col;
  logic [8:0] row;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, cmd, col, row, red_in, green_in, blue_in, input ready);
  modport sink (input valid, cmd, col, row, red_in, green_in, blue_in, output ready);
endinterface

interface rotr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       outside;

  modport source (output valid, red_out, green_out, blue_out, outside, input ready);
  modport sink (input valid, red_out, green_out, blue_out, outside, output ready);
endinterface

// ----- hdl/rotr_cfg.sv -----
module rotr_cfg import rotr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cos_q14    <= 16'sd16384;
      cfg.sin_q14    <= '0;
      cfg.offset_x   <= '0;
      cfg.offset_y   <= '0;
      cfg.src_width  <= 9'd256;
      cfg.src_height <= 9'd256;
    end else if (wr) begin
      unique case (idx)
        REG_COS:    cfg.cos_q14    <= pwdata[15:0];
        REG_SIN:    cfg.sin_q14    <= pwdata[15:0];
        REG_OFFX:   cfg.offset_x   <= pwdata[9:0];
        REG_OFFY:   cfg.offset_y   <= pwdata[9:0];
        REG_WIDTH:  cfg.src_width  <= pwdata[8:0];
        REG_HEIGHT: cfg.src_height <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_COS:    prdata = {16'b0, cfg.cos_q14};
      REG_SIN:    prdata = {16'b0, cfg.sin_q14};
      REG_OFFX:   prdata = {22'b0, cfg.offset_x};
      REG_OFFY:   prdata = {22'b0, cfg.offset_y};
      REG_WIDTH:  prdata = {23'b0, cfg.src_width};
      REG_HEIGHT: prdata = {23'b0, cfg.src_height};
      default:    prdata = '0;
    endcase
  end

endmodule

// ----- hdl/rotr_ram.sv -----
module rotr_ram import rotr_pkg::*; #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [PIX_W-1:0] wdata,
  output logic [PIX_W-1:0] rdata
);

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- hdl/rotr_map.sv -----
module rotr_map import rotr_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int AW         = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  rotr_in_if.sink       item,
  input  logic          adv,
  output acc_t          acc,
  output logic [AW-1:0] addr
);

  localparam logic [SUM_W-1:0] BIAS = {{(SUM_W-Q_SHIFT){1'b0}}, {Q_SHIFT{1'b1}}};

  logic v_a, v_b, v_c;
  logic en_a, en_b, en_c;

  logic             cmd_a, cmd_b, cmd_c;
  logic             ok_a, ok_b, ok_c;
  logic [8:0]       col_a, col_b, col_c;
  logic [8:0]       row_a, row_b, row_c;
  logic [PIX_W-1:0] pix_a, pix_b, pix_c;

  logic signed [10:0]       dx_a, dy_a;
  logic signed [PROD_W-1:0] pxc_b, pys_b, pyc_b, pxs_b;
  logic [SUM_W-1:0]         sum_x_c, sum_y_c;

  logic [SUM_W-1:0]   tx, ty;
  logic [COORD_W-1:0] sx, sy;
  logic               in_x, in_y;

  assign en_c       = !v_c || adv;
  assign en_b       = !v_b || en_c;
  assign en_a       = !v_a || en_b;
  assign item.ready = en_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
    end else begin
      if (en_a) v_a <= item.valid;
      if (en_b) v_b <= v_a;
      if (en_c) v_c <= v_b;
    end
  end

  // offsets and differences
  always_ff @(posedge clk) begin
    if (en_a && item.valid) begin
      cmd_a <= item.cmd;
      col_a <= item.col;
      row_a <= item.row;
      pix_a <= {item.red_in, item.green_in, item.blue_in};
      ok_a  <= (32'(item.col) < 32'(MAX_WIDTH)) && (32'(item.row) < 32'(MAX_HEIGHT));
      dx_a  <= {2'b00, item.col} - {cfg.offset_x[9], cfg.offset_x};
      dy_a  <= {2'b00, item.row} - {cfg.offset_y[9], cfg.offset_y};
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (en_b && v_a) begin
      cmd_b <= cmd_a;
      col_b <= col_a;
      row_b <= row_a;
      pix_b <= pix_a;
      ok_b  <= ok_a;
      pxc_b <= dx_a * cfg.cos_q14;
      pys_b <= dy_a * cfg.sin_q14;
      pyc_b <= dy_a * cfg.cos_q14;
      pxs_b <= dx_a * cfg.sin_q14;
    end
  end

  // sums
  always_ff @(posedge clk) begin
    if (en_c && v_b) begin
      cmd_c   <= cmd_b;
      col_c   <= col_b;
      row_c   <= row_b;
      pix_c   <= pix_b;
      ok_c    <= ok_b;
      sum_x_c <= {pxc_b[PROD_W-1], pxc_b} + {pys_b[PROD_W-1], pys_b};
      sum_y_c <= {pyc_b[PROD_W-1], pyc_b} - {pxs_b[PROD_W-1], pxs_b};
    end
  end

  // truncate toward zero, range check, store address
  always_comb begin
    tx   = sum_x_c + (sum_x_c[SUM_W-1] ? BIAS : '0);
    ty   = sum_y_c + (sum_y_c[SUM_W-1] ? BIAS : '0);
    sx   = tx[SUM_W-1:Q_SHIFT];
    sy   = ty[SUM_W-1:Q_SHIFT];
    in_x = !sx[COORD_W-1]
        && (32'(sx[COORD_W-2:0]) < 32'(cfg.src_width))
        && (32'(sx[COORD_W-2:0]) < 32'(MAX_WIDTH));
    in_y = !sy[COORD_W-1]
        && (32'(sy[COORD_W-2:0]) < 32'(cfg.src_height))
        && (32'(sy[COORD_W-2:0]) < 32'(MAX_HEIGHT));

    acc.valid = v_c;
    acc.fetch = (cmd_c == CMD_FETCH);
    acc.wdata = pix_c;
    if (cmd_c == CMD_FETCH) begin
      acc.hit = in_x && in_y;
      addr = AW'(32'(sy[COORD_W-2:0]) * 32'(MAX_WIDTH) + 32'(sx[COORD_W-2:0]));
    end else begin
      acc.hit = ok_c;
      addr = AW'(32'(row_c) * 32'(MAX_WIDTH) + 32'(col_c));
    end
  end

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> v_a)
    else $error("accepted transaction not captured");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    v_c && !adv |=> v_c && $stable(sum_x_c) && $stable(sum_y_c) && $stable(cmd_c))
    else $error("stalled stage lost its contents");

  a_no_ready_when_full: assert property (@(posedge clk) disable iff (rst)
    v_a && v_b && v_c && !adv |-> !item.ready)
    else $error("ready while pipeline is full and stalled");

endmodule

// ----- hdl/nearest_neighbor_image_rotator.sv -----
// channel  modport  payload                                  accepted when
// item     sink     cmd, col, row, red_in, green_in, blue_in  item.valid & item.ready
// result   source   red_out, green_out, blue_out, outside     result.valid & result.ready
// apb      slave    cos, sin, offsets, source size            psel & penable & pwrite
//
// one transaction per cycle unless a stalled result backs up every stage; a fetch result
// is registered (difference at acceptance, then multiply, sum, store read). loads use the
// same single store port in order, so a fetch always sees every earlier load. the store
// has no reset and no clearing pass; the block is ready right after reset. a stalled
// result only holds the stages behind it while they are full; bubbles keep closing up.
module nearest_neighbor_image_rotator import rotr_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic              clk,
  input  logic              rst,
  rotr_in_if.sink           item,
  rotr_out_if.source        result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  cfg_t             cfg;
  acc_t             acc;
  logic [AW-1:0]    addr;
  logic             adv;
  logic             ram_we, ram_re;
  logic [PIX_W-1:0] rdata;
  logic             res_valid;
  logic             res_outside;

  rotr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rotr_map #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_map (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (item),
    .adv  (adv),
    .acc  (acc),
    .addr (addr)
  );

  assign adv    = !res_valid || result.ready;
  assign ram_we = adv && acc.valid && !acc.fetch && acc.hit;
  assign ram_re = adv && acc.valid && acc.fetch && acc.hit;

  rotr_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (addr),
    .wdata (acc.wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= acc.valid && acc.fetch;
    end
    if (adv) begin
      res_outside <= !acc.hit;
    end
  end

  assign result.valid     = res_valid;
  assign result.outside   = res_outside;
  assign result.red_out   = res_outside ? WHITE : rdata[23:16];
  assign result.green_out = res_outside ? WHITE : rdata[15:8];
  assign result.blue_out  = res_outside ? WHITE : rdata[7:0];

  a_one_port_op: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("store read and write in one cycle");

  a_miss_is_white: assert property (@(posedge clk) disable iff (rst)
    adv && acc.valid && acc.fetch && !acc.hit |=> result.valid && result.outside)
    else $error("out of range fetch not flagged");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && $stable(res_outside)
      && $stable({result.red_out, result.green_out, result.blue_out}))
    else $error("stalled result changed");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import rotr_pkg::*;

  localparam int MAX_W = 256;
  localparam int MAX_H = 256;
  localparam int LIMIT = 400000;
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  typedef struct {
    logic       cmd;
    logic [8:0] col;
    logic [8:0] row;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       outside;
  } pix_res_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  rotr_in_if item_if ();
  rotr_out_if res_if ();

  nearest_neighbor_image_rotator #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  cfg_t cfg;
  logic [23:0] pix_mem [0:MAX_W*MAX_H-1];
  bit loaded [0:MAX_W*MAX_H-1];
  pix_req_t req_q[$];
  pix_res_t pix_exp_q[$];

  bit calm;
  bit in_fire = 1'b0;
  bit res_fire = 1'b0;
  int in_gap;
  int out_wait;
  int n_pushed;
  int n_taken;
  int n_results;
  int n_outside;
  int n_regw;
  int n_fail;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int draw_gap();
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(1, 13);
  endfunction

  // inverse mapping of an output coordinate onto the source image
  function automatic bit src_of(input logic [8:0] j, input logic [8:0] i, output int addr);
    int c, s, dx, dy, sx, sy, w, h;
    c = $signed(cfg.cos_q14);
    s = $signed(cfg.sin_q14);
    dx = int'(j) - $signed(cfg.offset_x);
    dy = int'(i) - $signed(cfg.offset_y);
    sx = (dx * c + dy * s) / (1 << Q_SHIFT);
    sy = (dy * c - dx * s) / (1 << Q_SHIFT);
    w = (cfg.src_width > MAX_W) ? MAX_W : int'(cfg.src_width);
    h = (cfg.src_height > MAX_H) ? MAX_H : int'(cfg.src_height);
    addr = sy * MAX_W + sx;
    return sx >= 0 && sx < w && sy >= 0 && sy < h;
  endfunction

  task automatic reg_write(input logic [2:0] idx, input int value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_COS:    cfg.cos_q14 = value[15:0];
      REG_SIN:    cfg.sin_q14 = value[15:0];
      REG_OFFX:   cfg.offset_x = value[9:0];
      REG_OFFY:   cfg.offset_y = value[9:0];
      REG_WIDTH:  cfg.src_width = value[8:0];
      REG_HEIGHT: cfg.src_height = value[8:0];
      default: ;
    endcase
    n_regw++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic add_load(input logic [8:0] j, input logic [8:0] i, input logic [23:0] rgb);
    req_q.push_back('{CMD_LOAD, j, i, rgb[23:16], rgb[15:8], rgb[7:0]});
    n_pushed++;
    if (j < MAX_W && i < MAX_H) loaded[i*MAX_W + j] = 1'b1;
  endtask

  // a fetch that lands on a never-loaded pixel gets that pixel loaded first
  task automatic add_fetch(input logic [8:0] j, input logic [8:0] i);
    int addr;
    if (src_of(j, i, addr) && !loaded[addr])
      add_load(9'(addr % MAX_W), 9'(addr / MAX_W), 24'($urandom));
    req_q.push_back('{CMD_FETCH, j, i, 8'($urandom), 8'($urandom), 8'($urandom)});
    n_pushed++;
  endtask

  task automatic add_random(input int count);
    int lim;
    logic [8:0] j, i;
    lim = (cfg.src_width == 0) ? 1 : ((cfg.src_width > MAX_W) ? MAX_W : cfg.src_width);
    repeat (count) begin
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 3))
          0: begin
            j = 9'($urandom);
            i = 9'($urandom);
          end
          1: begin
            j = 9'($urandom_range(0, MAX_W - 1));
            i = 9'($urandom_range(0, MAX_H - 1));
          end
          default: begin
            j = 9'($urandom_range(0, lim - 1));
            i = 9'($urandom_range(0, lim - 1));
          end
        endcase
        add_load(j, i, 24'($urandom));
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          j = 9'($urandom);
          i = 9'($urandom);
        end else begin
          j = cfg.offset_x[8:0] + 9'($urandom_range(0, 95)) - 9'd32;
          i = cfg.offset_y[8:0] + 9'($urandom_range(0, 95)) - 9'd32;
        end
        add_fetch(j, i);
      end
    end
  endtask

  task automatic wait_idle();
    while (n_taken != n_pushed || pix_exp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input int c, input int s, input int ox, input int oy,
                           input int w, input int h, input int count);
    wait_idle();
    reg_write(REG_COS, c);
    reg_write(REG_SIN, s);
    reg_write(REG_OFFX, ox);
    reg_write(REG_OFFY, oy);
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
    calm = ($urandom_range(0, 3) == 0);
    add_random(count);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb NOT OK");
      $finish;
    end
  end

  // input transactions update the pixel store or queue the expected pixel
  always @(posedge clk) begin : item_mon
    int addr;
    pix_res_t want;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= item_if.valid && item_if.ready;
      if (item_if.valid && item_if.ready) begin
        n_taken++;
        if (item_if.cmd == CMD_LOAD) begin
          if (item_if.col < MAX_W && item_if.row < MAX_H)
            pix_mem[item_if.row*MAX_W + item_if.col] =
              {item_if.red_in, item_if.green_in, item_if.blue_in};
        end else begin
          if (src_of(item_if.col, item_if.row, addr))
            want = {pix_mem[addr], 1'b0};
          else
            want = {WHITE, WHITE, WHITE, 1'b1};
          pix_exp_q.push_back(want);
        end
      end
    end
  end

  always @(posedge clk) begin : res_mon
    pix_res_t got;
    pix_res_t want;
    if (rst) begin
      res_fire <= 1'b0;
    end else begin
      res_fire <= res_if.valid && res_if.ready;
      if (res_if.valid && res_if.ready) begin
        got = {res_if.red_out, res_if.green_out, res_if.blue_out, res_if.outside};
        n_results++;
        if (got.outside) n_outside++;
        if (pix_exp_q.size() == 0) begin
          $display("%0t: unexpected transaction rgb %h outside %b", $time,
                   got[24:1], got.outside);
          n_fail++;
        end else begin
          want = pix_exp_q.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.outside !== want.outside) begin
            $display("%0t: mismatch expected rgb %h outside %b, actual rgb %h outside %b",
                     $time, want[24:1], want.outside, got[24:1], got.outside);
            n_fail++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin : item_drv
    pix_req_t nxt;
    if (rst) begin
      item_if.valid <= 1'b0;
      in_gap <= 0;
    end else if (!item_if.valid || in_fire) begin
      if (in_gap > 0) begin
        item_if.valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (req_q.size() != 0) begin
        nxt = req_q.pop_front();
        item_if.cmd <= nxt.cmd;
        item_if.col <= nxt.col;
        item_if.row <= nxt.row;
        item_if.red_in <= nxt.red;
        item_if.green_in <= nxt.green;
        item_if.blue_in <= nxt.blue;
        item_if.valid <= 1'b1;
        in_gap <= draw_gap();
      end else begin
        item_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : res_drv
    int stall;
    if (rst) begin
      res_if.ready <= 1'b0;
      out_wait <= 0;
    end else if (out_wait > 0) begin
      res_if.ready <= 1'b0;
      out_wait <= out_wait - 1;
    end else if (res_fire) begin
      stall = draw_gap();
      res_if.ready <= (stall == 0);
      out_wait <= (stall == 0) ? 0 : stall - 1;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_if.valid = 1'b0;
    item_if.cmd = CMD_LOAD;
    item_if.col = '0;
    item_if.row = '0;
    item_if.red_in = '0;
    item_if.green_in = '0;
    item_if.blue_in = '0;
    res_if.ready = 1'b0;
    cfg = '{cos_q14: 16'sd16384, sin_q14: 16'sd0, offset_x: 10'sd0, offset_y: 10'sd0,
            src_width: 9'd256, src_height: 9'd256};
    calm = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // identity mapping after reset: corners, ignored loads, outside fetches
    add_load(9'd0, 9'd0, 24'h000000);
    add_load(9'd255, 9'd255, 24'hffffff);
    add_load(9'd255, 9'd0, 24'hff00a5);
    add_load(9'd0, 9'd255, 24'h5a0fff);
    add_load(9'd256, 9'd0, 24'h123456);
    add_load(9'd0, 9'd256, 24'h654321);
    add_load(9'd511, 9'd511, 24'hc3c3c3);
    add_fetch(9'd0, 9'd0);
    add_fetch(9'd255, 9'd255);
    add_fetch(9'd255, 9'd0);
    add_fetch(9'd0, 9'd255);
    add_fetch(9'd256, 9'd0);
    add_fetch(9'd0, 9'd511);
    add_fetch(9'd511, 9'd511);

    // shear by a half: mapped values just below zero must count as inside
    run_phase(16384, -8192, 0, 0, 256, 256, 0);
    add_fetch(9'd0, 9'd1);
    add_fetch(9'd1, 9'd0);
    add_fetch(9'd0, 9'd3);
    add_random(40);

    run_phase(0, 16384, 0, 255, 256, 256, 45);
    run_phase(-16384, 0, 255, 255, 256, 256, 45);
    run_phase(16384, 0, 0, 0, 0, 37, 30);
    run_phase(16384, 0, 0, 0, 200, 0, 20);
    run_phase(11585, 11585, -512, 511, 511, 300, 45);
    run_phase(-32768, 32767, -512, -512, 1, 1, 40);
    wait_idle();
    reg_write(REG_SPARE_A, -1);
    reg_write(REG_SPARE_B, -1);
    calm = 1'b0;
    add_random(20);
    run_phase(16384, -16384, 511, -512, 256, 1, 40);
    run_phase(-16384, 16384, 0, 0, 1, 256, 40);
    repeat (5) begin
      run_phase($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                $urandom_range(0, 1023) - 512, $urandom_range(0, 1023) - 512,
                ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 32),
                ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 32), 40);
    end

    wait_idle();
    if (pix_exp_q.size() != 0) n_fail++;
    $display("%0d input transactions, %0d output pixels checked (%0d outside)",
             n_taken, n_results, n_outside);
    $display("%0d register writes across rotations, shears, empty and oversize images",
             n_regw);
    if (n_fail == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
